FILE: rtl/masked_byte_pattern_search_defines.svh
// assertion macros for the masked byte pattern search block
`ifndef MASKED_BYTE_PATTERN_SEARCH_DEFINES_SVH
`define MASKED_BYTE_PATTERN_SEARCH_DEFINES_SVH

// same-cycle implication, checked out of reset
`define MBPS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define MBPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/mbps_pkg.sv
// shared types and constants of the masked byte pattern search block
package mbps_pkg;

    // pattern positions held side by side in one memory row
    localparam int LANES  = 8;
    localparam int LANE_W = 3;

    localparam int MAX_PATTERN_DEF = 512;

    localparam int LEN_W    = 10;
    localparam int POS_W    = 9;
    localparam int BYTE_W   = 8;
    localparam int CNT_W    = 2;
    localparam int OFFS_W   = 32;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 40;

    // item kinds carried in tuser
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_DATA = 1'b1;

    // saturation point of the match count
    localparam logic [CNT_W-1:0] CNT_SAT = 2'd2;

    typedef struct packed {
        logic              care;
        logic [BYTE_W-1:0] pbyte;
    } t_lane_ent;

endpackage

FILE: rtl/mbps_store.sv
// row-organised pattern and partial-match memories with registered reads
module mbps_store #(
    parameter int ROWS  = 64,
    parameter int ROW_W = 6
) (
    input  logic                                  i_clk,
    input  logic                                  i_rd_en,
    input  logic [ROW_W-1:0]                      i_rd_row,
    output mbps_pkg::t_lane_ent [mbps_pkg::LANES-1:0] o_pat_q,
    output logic [mbps_pkg::LANES-1:0]            o_pm_q,
    input  logic                                  i_pat_wr_en,
    input  logic [ROW_W-1:0]                      i_pat_wr_row,
    input  logic [mbps_pkg::LANE_W-1:0]           i_pat_wr_lane,
    input  mbps_pkg::t_lane_ent                   i_pat_wr_ent,
    input  logic                                  i_pm_wr_en,
    input  logic [ROW_W-1:0]                      i_pm_wr_row,
    input  logic [mbps_pkg::LANES-1:0]            i_pm_wr_data
);
    import mbps_pkg::*;

    t_lane_ent [LANES-1:0] r_pat_mem [ROWS];
    logic      [LANES-1:0] r_pm_mem  [ROWS];

    // pattern memory: lane write per load, whole row read per sweep step
    always_ff @(posedge i_clk) begin
        if (i_pat_wr_en) begin
            r_pat_mem[i_pat_wr_row][i_pat_wr_lane] <= i_pat_wr_ent;
        end
        if (i_rd_en) begin
            o_pat_q <= r_pat_mem[i_rd_row];
        end
    end

    // partial-match memory: whole-row read and write back
    always_ff @(posedge i_clk) begin
        if (i_pm_wr_en) begin
            r_pm_mem[i_pm_wr_row] <= i_pm_wr_data;
        end
        if (i_rd_en) begin
            o_pm_q <= r_pm_mem[i_rd_row];
        end
    end

endmodule

FILE: rtl/mbps_row_update.sv
// shift-and update of one memory row of partial-match bits
module mbps_row_update (
    input  logic [mbps_pkg::BYTE_W-1:0]               i_byte,
    input  mbps_pkg::t_lane_ent [mbps_pkg::LANES-1:0] i_pat,
    input  logic [mbps_pkg::LANES-1:0]                i_pm_old,
    input  logic                                      i_carry,
    input  logic                                      i_tgt_en,
    input  logic [mbps_pkg::LANE_W-1:0]               i_tgt_lane,
    output logic [mbps_pkg::LANES-1:0]                o_pm_new,
    output logic                                      o_hit
);
    import mbps_pkg::*;

    logic [LANES-1:0] lane_ok;
    logic [LANES-1:0] prev_bit;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            lane_ok[l] = !i_pat[l].care || (i_pat[l].pbyte == i_byte);
        end
        prev_bit = {i_pm_old[LANES-2:0], i_carry};
        o_pm_new = prev_bit & lane_ok;
    end

    assign o_hit = i_tgt_en && o_pm_new[i_tgt_lane];

endmodule

FILE: rtl/masked_byte_pattern_search.sv
// top level: masked byte pattern search, control sequencer and block counters
// a load item is written as it is taken; a data item sweeps ROWS = ceil(MAX_PATTERN/8) rows,
// reading the partial-match memory one row of 8 positions per cycle and writing each row back
// the result is registered in the final step of the closing item, once the result register is free
// after reset a clearing pass over all ROWS rows zeroes the partial-match memory,
// during which no item is taken; the pattern memory is not cleared
`include "masked_byte_pattern_search_defines.svh"

module masked_byte_pattern_search #(
    parameter int MAX_PATTERN = mbps_pkg::MAX_PATTERN_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration: pattern_length
    input  logic                              i_cfg_wr_en,
    input  logic [mbps_pkg::LEN_W-1:0]        i_cfg_wr_data,
    // input items
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // position[8:0], pattern_byte[16:9], care[17], data_byte[25:18], zero[31:26]
    input  logic [mbps_pkg::S_DATA_W-1:0]     i_s_axis_tdata,
    // req_type[0]
    input  logic [0:0]                        i_s_axis_tuser,
    input  logic                              i_s_axis_tlast,
    // result items
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // match_count[1:0], first_offset[33:2], zero[39:34]
    output logic [mbps_pkg::M_DATA_W-1:0]     o_m_axis_tdata
);
    import mbps_pkg::*;

    localparam int ROWS  = (MAX_PATTERN + LANES - 1) / LANES;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

    // sequencer states
    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_SWEEP = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    // input field unpacking
    logic [POS_W-1:0]  s_pos;
    logic [BYTE_W-1:0] s_pbyte;
    logic              s_care;
    logic [BYTE_W-1:0] s_dbyte;
    logic              s_req;

    assign s_pos   = i_s_axis_tdata[8:0];
    assign s_pbyte = i_s_axis_tdata[16:9];
    assign s_care  = i_s_axis_tdata[17];
    assign s_dbyte = i_s_axis_tdata[25:18];
    assign s_req   = i_s_axis_tuser[0];

    // control state
    logic [1:0]        r_state,    n_state;
    logic [ROW_W-1:0]  r_row,      n_row;      // row address being read
    logic              r_issue,    n_issue;    // reads still to issue in this sweep
    logic              r_wb_v,     n_wb_v;     // read data present, write back this cycle
    logic [ROW_W-1:0]  r_wb_row,   n_wb_row;
    logic              r_carry,    n_carry;    // old top bit of the row below
    logic              r_hit,      n_hit;      // full-pattern match seen in this sweep
    logic              r_last,     n_last;
    logic [LEN_W-1:0]  r_len;
    logic [OFFS_W-1:0] r_offset,   n_offset;   // offset of the next data byte
    logic [CNT_W-1:0]  r_cnt,      n_cnt;
    logic [OFFS_W-1:0] r_first,    n_first;
    logic              r_out_valid, n_out_valid;
    // payload
    logic [BYTE_W-1:0] r_byte,     n_byte;
    logic [CNT_W-1:0]  r_out_cnt,  n_out_cnt;
    logic [OFFS_W-1:0] r_out_first, n_out_first;

    logic in_acc;
    logic out_free;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;

    // pattern length decode: target position is length minus one
    logic              len_ok;
    logic [LEN_W-1:0]  tgt;
    logic [ROW_W-1:0]  tgt_row;
    logic [LANE_W-1:0] tgt_lane;

    assign len_ok   = (r_len != '0) && (32'(r_len) <= MAX_PATTERN);
    assign tgt      = r_len - LEN_W'(1);
    assign tgt_row  = ROW_W'(32'(tgt) >> LANE_W);
    assign tgt_lane = tgt[LANE_W-1:0];

    // memory ports
    logic                    rd_en;
    t_lane_ent [LANES-1:0]   pat_q;
    logic [LANES-1:0]        pm_q;
    logic                    pat_wr_en;
    logic [ROW_W-1:0]        pat_wr_row;
    t_lane_ent               pat_wr_ent;
    logic                    pm_wr_en;
    logic [ROW_W-1:0]        pm_wr_row;
    logic [LANES-1:0]        pm_wr_data;
    logic [LANES-1:0]        pm_new;
    logic                    row_hit;

    assign rd_en = (r_state == ST_SWEEP) && r_issue;

    // loads beyond the store are dropped
    assign pat_wr_en        = in_acc && (s_req == REQ_LOAD) && (32'(s_pos) < MAX_PATTERN);
    assign pat_wr_row       = ROW_W'(32'(s_pos) >> LANE_W);
    assign pat_wr_ent.care  = s_care;
    assign pat_wr_ent.pbyte = s_pbyte;

    // write back: the updated row, or zero rows in the clearing pass and on the closing byte of a block
    always_comb begin
        pm_wr_en   = 1'b0;
        pm_wr_row  = r_wb_row;
        pm_wr_data = pm_new;
        if (r_state == ST_CLEAR) begin
            pm_wr_en   = 1'b1;
            pm_wr_row  = r_row;
            pm_wr_data = '0;
        end else if ((r_state == ST_SWEEP) && r_wb_v) begin
            pm_wr_en = 1'b1;
            if (r_last) begin
                pm_wr_data = '0;
            end
        end
    end

    mbps_store #(
        .ROWS  (ROWS),
        .ROW_W (ROW_W)
    ) u_store (
        .i_clk         (i_clk),
        .i_rd_en       (rd_en),
        .i_rd_row      (r_row),
        .o_pat_q       (pat_q),
        .o_pm_q        (pm_q),
        .i_pat_wr_en   (pat_wr_en),
        .i_pat_wr_row  (pat_wr_row),
        .i_pat_wr_lane (s_pos[LANE_W-1:0]),
        .i_pat_wr_ent  (pat_wr_ent),
        .i_pm_wr_en    (pm_wr_en),
        .i_pm_wr_row   (pm_wr_row),
        .i_pm_wr_data  (pm_wr_data)
    );

    mbps_row_update u_row_update (
        .i_byte     (r_byte),
        .i_pat      (pat_q),
        .i_pm_old   (pm_q),
        .i_carry    (r_carry),
        .i_tgt_en   (r_wb_v && len_ok && (r_wb_row == tgt_row)),
        .i_tgt_lane (tgt_lane),
        .o_pm_new   (pm_new),
        .o_hit      (row_hit)
    );

    // sequencer and block counters
    always_comb begin
        logic [CNT_W-1:0]  cnt_upd;
        logic [OFFS_W-1:0] first_upd;

        n_state     = r_state;
        n_row       = r_row;
        n_issue     = r_issue;
        n_wb_v      = r_wb_v;
        n_wb_row    = r_wb_row;
        n_carry     = r_carry;
        n_hit       = r_hit;
        n_last      = r_last;
        n_offset    = r_offset;
        n_cnt       = r_cnt;
        n_first     = r_first;
        n_byte      = r_byte;
        n_out_cnt   = r_out_cnt;
        n_out_first = r_out_first;
        n_out_valid = r_out_valid;
        if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        cnt_upd   = r_cnt;
        first_upd = r_first;
        if (r_hit) begin
            if (r_cnt == '0) begin
                first_upd = r_offset - OFFS_W'(tgt);
            end
            if (r_cnt != CNT_SAT) begin
                cnt_upd = r_cnt + CNT_W'(1);
            end
        end

        unique case (r_state)
            ST_CLEAR: begin
                n_row = r_row + ROW_W'(1);
                if (r_row == LAST_ROW) begin
                    n_row   = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_acc && (s_req == REQ_DATA)) begin
                    n_state = ST_SWEEP;
                    n_row   = '0;
                    n_issue = 1'b1;
                    n_wb_v  = 1'b0;
                    n_carry = 1'b1;    // position 0 has no predecessor
                    n_hit   = 1'b0;
                    n_byte  = s_dbyte;
                    n_last  = i_s_axis_tlast;
                end
            end
            ST_SWEEP: begin
                n_wb_v   = r_issue;
                n_wb_row = r_row;
                if (r_issue) begin
                    if (r_row == LAST_ROW) begin
                        n_issue = 1'b0;
                    end else begin
                        n_row = r_row + ROW_W'(1);
                    end
                end
                if (r_wb_v) begin
                    n_carry = pm_q[LANES-1];
                    if (row_hit) begin
                        n_hit = 1'b1;
                    end
                    if (r_wb_row == LAST_ROW) begin
                        n_state = ST_FIN;
                    end
                end
            end
            ST_FIN: begin
                // a closing byte waits here until the result register is free
                if (!r_last || out_free) begin
                    n_state = ST_IDLE;
                    n_cnt   = cnt_upd;
                    n_first = first_upd;
                    if (r_offset != '1) begin
                        n_offset = r_offset + OFFS_W'(1);
                    end
                    if (r_last) begin
                        n_out_valid = 1'b1;
                        n_out_cnt   = cnt_upd;
                        n_out_first = (cnt_upd != '0) ? first_upd : '0;
                        n_offset    = '0;
                        n_cnt       = '0;
                        n_first     = '0;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_row       <= '0;
            r_issue     <= 1'b0;
            r_wb_v      <= 1'b0;
            r_wb_row    <= '0;
            r_carry     <= 1'b0;
            r_hit       <= 1'b0;
            r_last      <= 1'b0;
            r_len       <= '0;
            r_offset    <= '0;
            r_cnt       <= '0;
            r_first     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_issue     <= n_issue;
            r_wb_v      <= n_wb_v;
            r_wb_row    <= n_wb_row;
            r_carry     <= n_carry;
            r_hit       <= n_hit;
            r_last      <= n_last;
            r_offset    <= n_offset;
            r_cnt       <= n_cnt;
            r_first     <= n_first;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_len <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte      <= n_byte;
        r_out_cnt   <= n_out_cnt;
        r_out_first <= n_out_first;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(M_DATA_W - OFFS_W - CNT_W)'(0), r_out_first, r_out_cnt};

    // a data item closes input until its sweep is done
    `MBPS_ASSERT_NEXT(a_data_blocks_input, in_acc && (s_req == REQ_DATA), !o_s_axis_tready, "input taken during a sweep")

    // a result only appears from the final step of a closing byte
    `MBPS_ASSERT_NOW(a_result_source, $rose(o_m_axis_tvalid), ($past(r_state) == ST_FIN) && $past(r_last), "result without a closing byte")

    // the match count saturates at two
    `MBPS_ASSERT_NOW(a_count_range, o_m_axis_tvalid, r_out_cnt != 2'd3, "match count beyond saturation")

    // write back never runs past the last memory row
    `MBPS_ASSERT_NOW(a_wb_row_range, r_wb_v, r_wb_row <= LAST_ROW, "write back outside the memory")

endmodule

FILE: test/mbps_checker.sv
// checker for the masked byte pattern search: predicts scan results and compares them
`timescale 1ns / 1ps

module mbps_checker #(
    parameter int MAX_PATTERN = mbps_pkg::MAX_PATTERN_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [mbps_pkg::LEN_W-1:0]    i_cfg_wr_data,
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    // position[8:0], pattern_byte[16:9], care[17], data_byte[25:18], zero[31:26]
    input  logic [mbps_pkg::S_DATA_W-1:0] i_s_tdata,
    // req_type[0]
    input  logic [0:0]                    i_s_tuser,
    input  logic                          i_s_tlast,
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    // match_count[1:0], first_offset[33:2], zero[39:34]
    input  logic [mbps_pkg::M_DATA_W-1:0] i_m_tdata,
    output int                            o_fail_count,
    output int                            o_pending
);

    typedef struct packed {
        logic [mbps_pkg::CNT_W-1:0]  match_cnt;
        logic [mbps_pkg::OFFS_W-1:0] first_offs;
    } t_scan_result;

    // bits needed to pick one pattern position
    localparam int PIDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    logic [mbps_pkg::BYTE_W-1:0] pat_mem  [MAX_PATTERN];
    logic                        care_mem [MAX_PATTERN];
    logic [MAX_PATTERN-1:0]      prefix_ok;
    logic [mbps_pkg::OFFS_W-1:0] byte_offs;
    logic [mbps_pkg::OFFS_W-1:0] first_offs;
    logic [mbps_pkg::CNT_W-1:0]  hits;
    logic [mbps_pkg::LEN_W-1:0]  pat_len;
    t_scan_result                expected_results [$];

    task automatic clear_block();
        prefix_ok  = '0;
        byte_offs  = '0;
        first_offs = '0;
        hits       = '0;
    endtask

    // shift-and step over one data byte
    task automatic scan_byte(input logic [mbps_pkg::BYTE_W-1:0] b, input logic lst);
        logic [MAX_PATTERN-1:0] byte_ok;
        t_scan_result           res;
        int                     k;
        for (k = 0; k < MAX_PATTERN; k++)
            byte_ok[k] = !care_mem[k] || (pat_mem[k] == b);
        prefix_ok = ((prefix_ok << 1) | MAX_PATTERN'(1)) & byte_ok;
        if (pat_len != 0 && pat_len <= MAX_PATTERN &&
            prefix_ok[PIDX_W'(pat_len - 1'b1)] === 1'b1) begin
            if (hits == 0)
                first_offs = byte_offs - (32'(pat_len) - 32'd1);
            if (hits < mbps_pkg::CNT_SAT)
                hits = hits + 1'b1;
        end
        if (byte_offs != '1)
            byte_offs = byte_offs + 1'b1;
        if (lst) begin
            res.match_cnt  = hits;
            res.first_offs = (hits != 0) ? first_offs : '0;
            expected_results.push_back(res);
            clear_block();
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_scan_result got;
        t_scan_result want;
        int           k;
        int           pos;
        if (!i_rst_n) begin
            for (k = 0; k < MAX_PATTERN; k++) begin
                pat_mem[k]  = '0;
                care_mem[k] = 1'b0;
            end
            clear_block();
            pat_len = '0;
            expected_results.delete();
            o_fail_count = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.match_cnt  = i_m_tdata[1:0];
                got.first_offs = i_m_tdata[33:2];
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, actual count %0d offset %0d",
                             $time, got.match_cnt, got.first_offs);
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.match_cnt !== want.match_cnt) begin
                        $display("%0t: match count expected %0d actual %0d",
                                 $time, want.match_cnt, got.match_cnt);
                        o_fail_count++;
                    end
                    if (got.first_offs !== want.first_offs) begin
                        $display("%0t: first offset expected %0d actual %0d",
                                 $time, want.first_offs, got.first_offs);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_wr_en)
                pat_len = i_cfg_wr_data;
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser[0] == mbps_pkg::REQ_LOAD) begin
                    pos = int'(i_s_tdata[8:0]);
                    if (pos < MAX_PATTERN) begin
                        pat_mem[pos]  = i_s_tdata[16:9];
                        care_mem[pos] = i_s_tdata[17];
                    end
                end else begin
                    scan_byte(i_s_tdata[25:18], i_s_tlast);
                end
            end
        end
        o_pending = expected_results.size();
    end

endmodule

FILE: test/tb.sv
// testbench top: stimulus for the masked byte pattern search and the final verdict
`timescale 1ns / 1ps

module tb;

    // one data item sweeps the partial-match memory row by row
    localparam int ROWS        = (mbps_pkg::MAX_PATTERN_DEF + mbps_pkg::LANES - 1)
                                 / mbps_pkg::LANES;
    // quiet time before a register write and at the end: covers an item still in flight
    localparam int SETTLE      = 2 * (ROWS + 3) + 16;
    localparam int ITEM_TARGET = 1550;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int NPOS        = mbps_pkg::MAX_PATTERN_DEF;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_wr_en;
    logic [mbps_pkg::LEN_W-1:0]    cfg_wr_data;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [mbps_pkg::S_DATA_W-1:0] s_tdata;
    logic [0:0]                    s_tuser;
    logic                          s_tlast;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [mbps_pkg::M_DATA_W-1:0] m_tdata;
    int                            fail_count;
    int                            pending;

    // stimulus-side copy of the pattern, used to plant matches in the data
    logic [7:0]                    shadow_pat  [NPOS];
    logic                          shadow_care [NPOS];
    logic [7:0]                    blk_bytes   [$];
    int                            n_items = 0;
    int                            cycles  = 0;
    int                            rdy_hold = 0;
    // full-speed stretch: no gaps on either side
    bit                            burst;

    masked_byte_pattern_search i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    mbps_checker i_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .i_s_tlast     (s_tlast),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL masked_byte_pattern_search");
            $finish;
        end
    end

    // result sink: random ready with mostly short stalls and the odd long one
    always @(posedge clk) begin : sink
        int r;
        if (burst) begin
            m_tready <= 1'b1;
            rdy_hold = 0;
        end else if (rdy_hold > 0) begin
            rdy_hold--;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                m_tready <= 1'b1;
                rdy_hold = $urandom_range(0, 7);
            end else if (r < 90) begin
                m_tready <= 1'b0;
                rdy_hold = $urandom_range(0, 2);
            end else if (r < 98) begin
                m_tready <= 1'b0;
                rdy_hold = $urandom_range(3, 19);
            end else begin
                m_tready <= 1'b0;
                rdy_hold = $urandom_range(50, 200);
            end
        end
    end

    // narrow picks come from a small alphabet so that matches happen by chance
    function automatic logic [7:0] pick_byte(input bit narrow);
        logic [7:0] v;
        v = 8'($urandom);
        if (narrow) begin
            case ($urandom_range(0, 4))
                0: v = 8'h00;
                1: v = 8'hFF;
                2: v = 8'h5A;
                3: v = 8'hA5;
                default: v = v;
            endcase
        end
        return v;
    endfunction

    // drive one item after a random gap and hold it until accepted
    task automatic send_item(input logic req, input logic [8:0] pos, input logic [7:0] pb,
                             input logic care, input logic [7:0] db, input logic lst);
        int gap;
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 60)
            gap = 0;
        else if (r < 90)
            gap = $urandom_range(1, 3);
        else if (r < 98)
            gap = $urandom_range(4, 15);
        else
            gap = $urandom_range(20, 150);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, db, care, pb, pos};
        s_tuser  <= req;
        s_tlast  <= lst;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        n_items++;
    endtask

    // load item: unused data byte and last bit are random
    task automatic load_pos(input logic [8:0] pos, input logic [7:0] pb, input logic care);
        shadow_pat[pos]  = pb;
        shadow_care[pos] = care;
        send_item(mbps_pkg::REQ_LOAD, pos, pb, care, 8'($urandom), 1'($urandom));
    endtask

    // data item: unused load fields are random
    task automatic send_byte(input logic [7:0] db, input logic lst);
        send_item(mbps_pkg::REQ_DATA, 9'($urandom), 8'($urandom), 1'($urandom), db, lst);
    endtask

    // stream blk_bytes as one block, optionally with stray loads in between
    task automatic send_block(input bit noisy);
        int i;
        for (i = 0; i < blk_bytes.size(); i++) begin
            if (noisy && $urandom_range(0, 15) == 0)
                load_pos(9'($urandom), pick_byte(1'b1), 1'($urandom));
            send_byte(blk_bytes[i], i == blk_bytes.size() - 1);
        end
    endtask

    // wait for every result, then let any item still in the sweep finish
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_length(input logic [mbps_pkg::LEN_W-1:0] v);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin : stim
        int len;
        int eff;
        int n_bytes;
        int n_plants;
        int n_blocks;
        int off;
        int phase;
        int i;
        int j;
        int p;
        bit narrow;

        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        s_tlast     = 1'b0;
        m_tready    = 1'b0;
        burst       = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // write every pattern position once so no scan ever reads an unwritten entry
        for (i = 0; i < NPOS; i++)
            load_pos(9'(i), pick_byte(i % 2 == 1), 1'($urandom));

        // length zero never matches
        write_length(0);
        blk_bytes = '{8'h00, 8'hFF, 8'h00};
        send_block(1'b0);

        // single cared byte hit three times: count saturates, first hit at 1
        write_length(1);
        load_pos(9'd0, 8'hFF, 1'b1);
        blk_bytes = '{8'h00, 8'hFF, 8'h7E, 8'hFF, 8'hFF};
        send_block(1'b0);

        // wildcard in the second position; first a block shorter than the pattern
        write_length(2);
        load_pos(9'd0, 8'h00, 1'b1);
        load_pos(9'd1, 8'h55, 1'b0);
        blk_bytes = '{8'h00};
        send_block(1'b0);
        // then a unique hit through the wildcard
        blk_bytes = '{8'h11, 8'h00, 8'hAB};
        send_block(1'b0);

        // length beyond the pattern store never matches
        write_length(10'h3FF);
        blk_bytes = '{8'hFF, 8'hFF};
        send_block(1'b0);

        // random phases: a length setting, then a few blocks with fresh or kept patterns
        // the first phase scans once with the full pattern store as loaded at the start
        phase = 0;
        while (n_items < ITEM_TARGET) begin
            if (phase == 0) begin
                len = NPOS;
            end else begin
                p = $urandom_range(0, 99);
                if (p < 40)
                    len = $urandom_range(1, 3);
                else if (p < 70)
                    len = $urandom_range(4, 8);
                else if (p < 85)
                    len = $urandom_range(9, 24);
                else if (p < 90)
                    len = $urandom_range(25, 48);
                else if (p < 95)
                    len = 0;
                else
                    len = $urandom_range(NPOS + 1, 1023);
            end
            write_length(len);
            burst    = ($urandom_range(0, 4) == 0);
            eff      = (len <= NPOS) ? len : 0;
            n_blocks = (phase == 0) ? 1 : $urandom_range(2, 4);
            for (j = 0; j < n_blocks; j++) begin
                narrow = ($urandom_range(0, 3) != 0);
                if (phase != 0 && (j == 0 || $urandom_range(0, 1) == 1)) begin
                    for (i = 0; i < eff; i++)
                        load_pos(9'(i), pick_byte(narrow), $urandom_range(0, 3) != 0);
                end
                // mostly a little longer than the pattern, sometimes shorter
                if (phase == 0)
                    n_bytes = eff + 1;
                else if (eff > 1 && $urandom_range(0, 6) == 0)
                    n_bytes = $urandom_range(1, eff - 1);
                else
                    n_bytes = eff + $urandom_range(0, 10) + ((eff == 0) ? 1 : 0);
                blk_bytes.delete();
                for (i = 0; i < n_bytes; i++)
                    blk_bytes.push_back(pick_byte(narrow));
                // plant whole copies of the cared pattern bytes
                if (eff == 0 || n_bytes < eff)
                    n_plants = 0;
                else if (phase == 0)
                    n_plants = 1;
                else
                    n_plants = $urandom_range(0, 3);
                for (p = 0; p < n_plants; p++) begin
                    off = $urandom_range(0, n_bytes - eff);
                    for (i = 0; i < eff; i++)
                        if (shadow_care[i])
                            blk_bytes[off + i] = shadow_pat[i];
                end
                // now and then break a near match
                if ($urandom_range(0, 3) == 0)
                    blk_bytes[$urandom_range(0, n_bytes - 1)] ^= 8'h01;
                send_block(phase != 0 && $urandom_range(0, 3) == 0);
            end
            burst = 1'b0;
            phase++;
        end

        wait_idle();
        if (fail_count == 0 && pending == 0)
            $display("PASS masked_byte_pattern_search");
        else
            $display("FAIL masked_byte_pattern_search");
        $finish;
    end

endmodule
